[hw/rtl/set_pkg.sv]
`default_nettype none

package set_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int THRESH_W   = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register reset values and size floor
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
    localparam logic [THRESH_W-1:0] THRESH_RST = 11'd100;
    localparam int                  MIN_DIM    = 3;

    // Arithmetic widths: |g| <= 4 * 255, so g fits in PIX_W + 3 signed bits
    // and g squared stays below 2^20.
    localparam int GRAD_W = PIX_W + 3;
    localparam int SUM_W  = PIX_W + 2;
    localparam int SQ_W   = 2 * GRAD_W - 2;
    localparam int MAG_W  = 2 * THRESH_W;

    // Result codes
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;
    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int USED_W     = FIFO_CNT_W + 1;
    localparam int CORE_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Control that travels with a pixel after its line store read
    typedef struct packed {
        logic vld;   // pixel in this stage
        logic prod;  // window is complete, a result follows
        logic last;  // last interior pixel of the frame
    } t_s1_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/set_if.sv]
`default_nettype none

interface set_pix_if import set_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface set_res_if import set_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;

    modport source (output valid, output edge_value, output frame_last, input ready);
    modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

interface set_cfg_if import set_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/set_line_mem.sv]
`default_nettype none

// Two line stores side by side: upper byte holds row r-2, lower byte row r-1.
module set_line_mem import set_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [COL_W-1:0]   i_rd_addr,
    output logic [2*PIX_W-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [COL_W-1:0]   i_wr_addr,
    input  logic [2*PIX_W-1:0] i_wr_data
);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/set_sobel_core.sv]
`default_nettype none

// Window, gradients, squares, threshold compare. Never stalls: the caller
// admits a pixel only when the output queue has room for it.
module set_sobel_core import set_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_s1_ctl               i_s1,
    input  logic [PIX_W-1:0]      i_px,
    input  logic [PIX_W-1:0]      i_top,
    input  logic [PIX_W-1:0]      i_mid,
    input  logic [THRESH_W-1:0]   i_thresh,
    output logic                  o_push,
    output t_res                  o_res,
    output logic [CORE_CNT_W-1:0] o_inflight
);

    localparam int SQF_W = 2 * GRAD_W;

    // [row][col], col 0 oldest; row 0 is the top line
    logic [PIX_W-1:0] r_win [3][3];

    logic r_s2_prod, r_s2_last;
    logic r_s3_prod, r_s3_last;
    logic r_s4_prod, r_s4_last;

    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic [SQ_W-1:0]          r_sqx, r_sqy;
    logic [MAG_W-1:0]         r_th_sq;

    logic [SUM_W-1:0]         w_gx_pos, w_gx_neg, w_gy_pos, w_gy_neg;
    logic signed [GRAD_W-1:0] n_gx, n_gy;
    logic signed [SQF_W-1:0]  w_sqx_full, w_sqy_full;
    logic [MAG_W-1:0]         w_mag;

    always_ff @(posedge i_clk) begin
        if (i_s1.vld) begin
            for (int j = 0; j < 3; j++) begin
                r_win[j][0] <= r_win[j][1];
                r_win[j][1] <= r_win[j][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_px;
        end
    end

    always_comb begin
        w_gx_pos = SUM_W'(r_win[0][2]) + {1'b0, r_win[1][2], 1'b0} + SUM_W'(r_win[2][2]);
        w_gx_neg = SUM_W'(r_win[0][0]) + {1'b0, r_win[1][0], 1'b0} + SUM_W'(r_win[2][0]);
        w_gy_pos = SUM_W'(r_win[2][0]) + {1'b0, r_win[2][1], 1'b0} + SUM_W'(r_win[2][2]);
        w_gy_neg = SUM_W'(r_win[0][0]) + {1'b0, r_win[0][1], 1'b0} + SUM_W'(r_win[0][2]);
        n_gx     = $signed({1'b0, w_gx_pos}) - $signed({1'b0, w_gx_neg});
        n_gy     = $signed({1'b0, w_gy_pos}) - $signed({1'b0, w_gy_neg});
    end

    assign w_sqx_full = SQF_W'(r_gx) * SQF_W'(r_gx);
    assign w_sqy_full = SQF_W'(r_gy) * SQF_W'(r_gy);

    always_ff @(posedge i_clk) begin
        r_gx    <= n_gx;
        r_gy    <= n_gy;
        r_sqx   <= w_sqx_full[SQ_W-1:0];
        r_sqy   <= w_sqy_full[SQ_W-1:0];
        r_th_sq <= MAG_W'(i_thresh) * MAG_W'(i_thresh);
        r_s2_last <= i_s1.last;
        r_s3_last <= r_s2_last;
        r_s4_last <= r_s3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_prod <= 1'b0;
            r_s3_prod <= 1'b0;
            r_s4_prod <= 1'b0;
        end else begin
            r_s2_prod <= i_s1.vld & i_s1.prod;
            r_s3_prod <= r_s2_prod;
            r_s4_prod <= r_s3_prod;
        end
    end

    assign w_mag            = MAG_W'(r_sqx) + MAG_W'(r_sqy);
    assign o_push           = r_s4_prod;
    assign o_res.edge_value = (w_mag < r_th_sq) ? EDGE_OFF : EDGE_ON;
    assign o_res.frame_last = r_s4_last;
    assign o_inflight       = CORE_CNT_W'(r_s2_prod) + CORE_CNT_W'(r_s3_prod)
                            + CORE_CNT_W'(r_s4_prod);

endmodule

`default_nettype wire

[hw/rtl/set_out_fifo.sv]
`default_nettype none

// Result queue between the compute pipeline and the output channel.
module set_out_fifo import set_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_res                  i_data,
    output logic [FIFO_CNT_W-1:0] o_count,
    set_res_if.source             o_res
);

    t_res                  r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign w_pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fifo[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(w_pop);
        end
    end

    assign o_res.valid      = (r_count != '0);
    assign o_res.edge_value = r_fifo[r_rd_ptr].edge_value;
    assign o_res.frame_last = r_fifo[r_rd_ptr].frame_last;
    assign o_count          = r_count;

endmodule

`default_nettype wire

[hw/rtl/sobel_edge_threshold.sv]
`default_nettype none

// Path: a transferred pixel passes stage 1 (line memory read), then the window,
// gradient and square registers; its result then enters the output queue.
// Throughput: one pixel per cycle while an output queue slot is free; each pixel makes one
// read and one write of the line memory (separate ports), and the 8-entry output queue absorbs output stalls.
// Border pixels produce no result; the first frame row of results follows row 2.
// Reset (synchronous, active low) restores width 640, height 480, threshold 100,
// zeroes the row/column counters and empties the pipeline; line memory is not cleared.
module sobel_edge_threshold import set_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    set_cfg_if.sink   i_cfg,
    set_pix_if.sink   i_pix,
    set_res_if.source o_res
);

    // Configuration registers
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [THRESH_W-1:0] r_thresh;

    // Raster position of the next pixel
    logic [COL_W-1:0]    r_col, n_col;
    logic [HEIGHT_W-1:0] r_row, n_row;

    // Stage 1: pixel waiting for its line memory read data
    t_s1_ctl             r_s1_ctl;
    logic [PIX_W-1:0]    r_s1_px;
    logic [COL_W-1:0]    r_s1_addr;

    logic [WIDTH_W-1:0]    w_w_eff;
    logic [HEIGHT_W-1:0]   w_h_eff;
    logic                  w_col_wrap;
    logic [HEIGHT_W:0]     w_row_pre, w_row_inc;
    logic [COL_W-1:0]      w_col_cur;
    logic [HEIGHT_W-1:0]   w_row_cur;
    logic [WIDTH_W-1:0]    w_col_inc;
    logic                  w_prod, w_last;
    logic                  w_accept;
    logic [2*PIX_W-1:0]    w_rd_data;
    logic                  w_push;
    t_res                  w_core_res;
    logic [CORE_CNT_W-1:0] w_core_cnt;
    logic [FIFO_CNT_W-1:0] w_fifo_cnt;
    logic [USED_W-1:0]     w_used;

    // ---------------- configuration port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:    r_width  <= i_cfg.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height <= i_cfg.data[HEIGHT_W-1:0];
                CFG_EDGE_THRESHOLD: r_thresh <= i_cfg.data[THRESH_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Saturate the frame size: width to [3, MAX_WIDTH], height to at least 3
    always_comb begin
        priority if (r_width < WIDTH_W'(MIN_DIM)) begin
            w_w_eff = WIDTH_W'(MIN_DIM);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            w_w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_w_eff = r_width;
        end
        w_h_eff = (r_height < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : r_height;
    end

    // ---------------- raster position ----------------
    // A position left beyond a size that shrank wraps before use; then advance
    // the column and wrap row and frame at their ends.
    always_comb begin
        w_col_wrap = WIDTH_W'(r_col) >= w_w_eff;
        w_row_pre  = w_col_wrap ? {1'b0, r_row} + 1'b1 : {1'b0, r_row};
        w_row_cur  = (w_row_pre >= (HEIGHT_W + 1)'(w_h_eff)) ? '0 : w_row_pre[HEIGHT_W-1:0];
        w_col_cur  = w_col_wrap ? '0 : r_col;

        w_col_inc  = WIDTH_W'(w_col_cur) + 1'b1;
        w_row_inc  = {1'b0, w_row_cur} + 1'b1;
        if (w_col_inc >= w_w_eff) begin
            n_col = '0;
            n_row = (w_row_inc >= (HEIGHT_W + 1)'(w_h_eff)) ? '0 : w_row_inc[HEIGHT_W-1:0];
        end else begin
            n_col = w_col_inc[COL_W-1:0];
            n_row = w_row_cur;
        end

        // Window covers rows r-2..r and columns c-2..c: interior pixel (r-1, c-1)
        w_prod = (w_row_cur >= HEIGHT_W'(2)) && (w_col_cur >= COL_W'(2));
        w_last = (w_row_cur == w_h_eff - 1'b1) && (WIDTH_W'(w_col_cur) == w_w_eff - 1'b1);
    end

    // ---------------- admission ----------------
    // Every pixel that will produce a result holds a queue slot from the
    // moment it is accepted, so the compute pipeline never has to stall.
    assign w_used      = USED_W'(w_fifo_cnt) + USED_W'(w_core_cnt)
                       + USED_W'(r_s1_ctl.vld & r_s1_ctl.prod);
    assign i_pix.ready = (w_used < USED_W'(FIFO_DEPTH));
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_ctl <= '0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_ctl.vld  <= w_accept;
            r_s1_ctl.prod <= w_prod;
            r_s1_ctl.last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px   <= i_pix.pixel;
            r_s1_addr <= w_col_cur;
        end
    end

    // ---------------- line memory ----------------
    // Read the column on transfer, write it back in the next cycle from stage 1: row r-1 moves
    // to the upper byte and the new pixel lands in the lower byte. Back-to-back
    // pixels always touch different columns (width is at least 3), so the
    // write never races a read of the same entry.
    set_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_col_cur),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1_ctl.vld),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({w_rd_data[PIX_W-1:0], r_s1_px})
    );

    // ---------------- compute ----------------
    set_sobel_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1       (r_s1_ctl),
        .i_px       (r_s1_px),
        .i_top      (w_rd_data[2*PIX_W-1:PIX_W]),
        .i_mid      (w_rd_data[PIX_W-1:0]),
        .i_thresh   (r_thresh),
        .o_push     (w_push),
        .o_res      (w_core_res),
        .o_inflight (w_core_cnt)
    );

    // ---------------- output queue ----------------
    set_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_core_res),
        .o_count (w_fifo_cnt),
        .o_res   (o_res)
    );

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= USED_W'(FIFO_DEPTH))
        else $error("result slots overcommitted");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fifo_cnt < FIFO_CNT_W'(FIFO_DEPTH)) || (o_res.valid && o_res.ready))
        else $error("output queue overflow");

    a_s1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_ctl.vld && (r_s1_addr == $past(w_col_cur)))
        else $error("stage 1 lost a transferred pixel");

    a_mem_no_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_s1_ctl.vld) |-> (w_col_cur != r_s1_addr))
        else $error("line memory read and write hit the same column");

endmodule

`default_nettype wire
